// ----- hdl/wfcs_pkg.sv -----
package wfcs_pkg;

   localparam int unsigned MAX_CHUNK_WORDS_DEF = 256;
   localparam int unsigned QUEUE_DEPTH_DEF     = 4;
   localparam logic [15:0] TIMEOUT_RESET       = 16'd10000;

   typedef enum logic [2:0] {
      REQ_ID           = 3'd0,
      REQ_CHIP_ERASE   = 3'd1,
      REQ_SECTOR_ERASE = 3'd2,
      REQ_PROGRAM      = 3'd3,
      REQ_BUFFER       = 3'd4,
      REQ_READ_RETURN  = 3'd5,
      REQ_TICK         = 3'd6,
      REQ_ABORT        = 3'd7
   } req_kind_type;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_ID    = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_ABORT   = 2'd2;

   localparam logic [23:0] ADDR_UNLOCK1 = 24'h000555;
   localparam logic [23:0] ADDR_UNLOCK2 = 24'h0002AA;
   localparam logic [23:0] ADDR_ZERO    = 24'h000000;
   localparam logic [23:0] ADDR_ID0     = 24'h000000;
   localparam logic [23:0] ADDR_ID1     = 24'h000001;
   localparam logic [23:0] ADDR_ID2     = 24'h00000E;
   localparam logic [23:0] ADDR_ID3     = 24'h00000F;
   localparam logic [23:0] SECTOR_MASK  = 24'hFF0000;

   localparam logic [15:0] CMD_UNLOCK1  = 16'h00AA;
   localparam logic [15:0] CMD_UNLOCK2  = 16'h0055;
   localparam logic [15:0] CMD_AUTOSEL  = 16'h0090;
   localparam logic [15:0] CMD_ERASE    = 16'h0080;
   localparam logic [15:0] CMD_CHIP     = 16'h0010;
   localparam logic [15:0] CMD_SECTOR   = 16'h0030;
   localparam logic [15:0] CMD_PROGRAM  = 16'h00A0;
   localparam logic [15:0] CMD_WBUF     = 16'h0025;
   localparam logic [15:0] CMD_WBUF_GO  = 16'h0029;
   localparam logic [15:0] CMD_RESET    = 16'h00F0;
   localparam int unsigned DQ7_BIT      = 7;

   typedef enum logic [3:0] {
      OP_ID     = 4'd0,
      OP_CHIP   = 4'd1,
      OP_SECTOR = 4'd2,
      OP_PROG   = 4'd3,
      OP_BUF    = 4'd4,
      OP_IDWORD = 4'd5,
      OP_MATCH  = 4'd6,
      OP_POLL   = 4'd7,
      OP_DONE   = 4'd8
   } op_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [24:0] byte_addr;
      logic [15:0] data_word;
      logic [8:0]  chunk_len;
      logic        chunk_first;
      logic        chunk_last;
      logic [15:0] read_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [23:0] bus_addr;
      logic [15:0] bus_data;
      logic [1:0]  done_status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  first_step;
      logic [2:0]  final_step;
      logic [23:0] addr_a;
      logic [23:0] addr_b;
      logic [15:0] data;
      logic [8:0]  count;
      logic [1:0]  status;
   } desc_type;

endpackage

// ----- hdl/word_flash_command_sequencer.sv -----
// Command sequencer for a 16-bit NOR flash with the common unlock protocol.
// req_ channel: host requests, returned bus reads, timer ticks and aborts, one
// transaction per item. rsp_ channel: bus writes, bus reads, ID words and done
// reports, with last set on the final result of an item. Both channels use
// valid and stall; the receiver stalls. csr_ writes the polling timeout in
// ticks (reset value 10000); csr_ready is always high.
// The front classifies one item per cycle while the queue has room and updates
// the operation state, then queues a command descriptor (QUEUE_DEPTH entries).
// The back expands a descriptor into 1 to 7 results, one per cycle while
// rsp_stall is low, through an output register. An accepted item's descriptor
// is first written into the queue, and the back then registers its first
// result in the output register. An item that causes k results holds the back
// until all k are produced; items causing no result queue no descriptor.
// req_stall rises when the queue is full, so a stalled rsp_ channel backs up
// into the queue and then into the req_ channel.
// Reset clears the operation state, the queue and the output valid; no
// clearing pass is needed.
module word_flash_command_sequencer
   import wfcs_pkg::*;
#(
   parameter int unsigned MAX_CHUNK_WORDS = MAX_CHUNK_WORDS_DEF,
   parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic     push_valid;
   desc_type push_desc;
   desc_type head_desc;
   logic     q_full;
   logic     q_empty;
   logic     pop;

   wfcs_front #(
      .MAX_CHUNK_WORDS(MAX_CHUNK_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_desc  (push_desc)
   );

   wfcs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .full      (q_full),
      .empty     (q_empty)
   );

   wfcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty together");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (q_empty && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared with nothing queued");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.out_kind != KIND_DONE)) |-> (rsp_payload.done_status == ST_OK))
      else $error("status set on a result that is not done");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ----- hdl/wfcs_front.sv -----
module wfcs_front
   import wfcs_pkg::*;
#(
   parameter int unsigned MAX_CHUNK_WORDS = MAX_CHUNK_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,
   input  logic        q_full,
   output logic        push_valid,
   output desc_type    push_desc
);

   logic        polling_ff, polling_in;
   logic [23:0] poll_addr_ff, poll_addr_in;
   logic        expected_ff, expected_in;
   logic [15:0] tick_ff, tick_in;
   logic [23:0] chunk_start_ff, chunk_start_in;
   logic [8:0]  offset_ff, offset_in;
   logic [1:0]  discard_ff, discard_in;
   logic [2:0]  id_left_ff, id_left_in;
   logic [15:0] timeout_ff;

   logic        accept;
   logic        idle;
   logic [23:0] waddr;
   logic [9:0]  len_w;
   logic [23:0] p;
   logic        buf_go;
   logic [2:0]  disc_add;
   logic        disc_dec;
   logic [3:0]  disc_sum;
   logic        emit;
   desc_type    desc;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_full;
   assign idle      = !polling_ff && (id_left_ff == 3'd0) && (offset_ff == 9'd0);
   assign waddr     = req_payload.byte_addr[24:1];
   assign disc_sum  = {2'b00, discard_ff} + {1'b0, disc_add};

   always_comb begin
      polling_in     = polling_ff;
      poll_addr_in   = poll_addr_ff;
      expected_in    = expected_ff;
      tick_in        = tick_ff;
      chunk_start_in = chunk_start_ff;
      offset_in      = offset_ff;
      id_left_in     = id_left_ff;
      disc_add       = 3'd0;
      disc_dec       = 1'b0;
      emit           = 1'b0;
      buf_go         = 1'b0;
      p              = waddr;
      len_w          = {1'b0, req_payload.chunk_len};
      desc.op         = OP_DONE;
      desc.first_step = 3'd0;
      desc.final_step = 3'd0;
      desc.addr_a     = waddr;
      desc.addr_b     = chunk_start_ff;
      desc.data       = req_payload.data_word;
      desc.count      = 9'd0;
      desc.status     = ST_OK;
      if (len_w == 10'd0) begin
         len_w = 10'd1;
      end
      if (len_w > 10'(MAX_CHUNK_WORDS)) begin
         len_w = 10'(MAX_CHUNK_WORDS);
      end
      case (req_payload.req_type)
         REQ_ID: begin
            if (idle) begin
               emit            = 1'b1;
               desc.op         = OP_ID;
               desc.final_step = 3'd6;
               id_left_in      = 3'd4;
            end
         end
         REQ_CHIP_ERASE: begin
            if (idle) begin
               emit            = 1'b1;
               desc.op         = OP_CHIP;
               desc.final_step = 3'd6;
            end
         end
         REQ_SECTOR_ERASE: begin
            if (idle) begin
               emit            = 1'b1;
               desc.op         = OP_SECTOR;
               desc.final_step = 3'd6;
               desc.addr_a     = waddr & SECTOR_MASK;
               polling_in      = 1'b1;
               poll_addr_in    = waddr & SECTOR_MASK;
               expected_in     = 1'b1;
               tick_in         = 16'd0;
            end
         end
         REQ_PROGRAM: begin
            if (idle) begin
               emit            = 1'b1;
               desc.op         = OP_PROG;
               desc.final_step = 3'd4;
               polling_in      = 1'b1;
               poll_addr_in    = waddr;
               expected_in     = req_payload.data_word[DQ7_BIT];
               tick_in         = 16'd0;
            end
         end
         REQ_BUFFER: begin
            if (!polling_ff && (id_left_ff == 3'd0)) begin
               if (req_payload.chunk_first) begin
                  buf_go          = 1'b1;
                  p               = waddr;
                  chunk_start_in  = waddr;
                  offset_in       = 9'd1;
                  desc.first_step = 3'd0;
               end else if (offset_ff != 9'd0) begin
                  buf_go          = 1'b1;
                  p               = 24'(chunk_start_ff + {15'd0, offset_ff});
                  offset_in       = offset_ff + 9'd1;
                  desc.first_step = 3'd4;
               end
               if (buf_go) begin
                  emit            = 1'b1;
                  desc.op         = OP_BUF;
                  desc.addr_a     = p;
                  desc.addr_b     = chunk_start_in;
                  desc.count      = 9'(len_w - 10'd1);
                  desc.final_step = 3'd4;
                  if (req_payload.chunk_last) begin
                     desc.final_step = 3'd6;
                     polling_in      = 1'b1;
                     poll_addr_in    = p;
                     expected_in     = req_payload.data_word[DQ7_BIT];
                     tick_in         = 16'd0;
                     offset_in       = 9'd0;
                  end
               end
            end
         end
         REQ_READ_RETURN: begin
            if (discard_ff != 2'd0) begin
               disc_dec = 1'b1;
            end else if (id_left_ff != 3'd0) begin
               emit       = 1'b1;
               desc.op    = OP_IDWORD;
               desc.data  = req_payload.read_value;
               id_left_in = id_left_ff - 3'd1;
               if (id_left_ff == 3'd1) begin
                  desc.final_step = 3'd2;
               end
            end else if (polling_ff) begin
               emit        = 1'b1;
               desc.addr_a = poll_addr_ff;
               if (req_payload.read_value[DQ7_BIT] == expected_ff) begin
                  desc.op         = OP_MATCH;
                  desc.final_step = 3'd2;
                  disc_add        = 3'd2;
                  polling_in      = 1'b0;
               end else begin
                  desc.op = OP_POLL;
               end
            end
         end
         REQ_TICK: begin
            if (polling_ff) begin
               if (tick_ff >= timeout_ff) begin
                  emit        = 1'b1;
                  desc.op     = OP_DONE;
                  desc.status = ST_TIMEOUT;
                  polling_in  = 1'b0;
                  disc_add    = 3'd1;
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
         end
         default: begin
            if (!idle) begin
               emit        = 1'b1;
               desc.op     = OP_DONE;
               desc.status = ST_ABORT;
               disc_add    = id_left_ff + {2'b00, polling_ff};
               polling_in  = 1'b0;
               id_left_in  = 3'd0;
               offset_in   = 9'd0;
            end
         end
      endcase
      if (disc_dec) begin
         discard_in = discard_ff - 2'd1;
      end else if (disc_sum > 4'd3) begin
         discard_in = 2'd3;
      end else begin
         discard_in = disc_sum[1:0];
      end
   end

   assign push_valid = accept && emit;
   assign push_desc  = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         polling_ff     <= 1'b0;
         poll_addr_ff   <= '0;
         expected_ff    <= 1'b0;
         tick_ff        <= '0;
         chunk_start_ff <= '0;
         offset_ff      <= '0;
         discard_ff     <= '0;
         id_left_ff     <= '0;
         timeout_ff     <= TIMEOUT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (accept) begin
            polling_ff     <= polling_in;
            poll_addr_ff   <= poll_addr_in;
            expected_ff    <= expected_in;
            tick_ff        <= tick_in;
            chunk_start_ff <= chunk_start_in;
            offset_ff      <= offset_in;
            discard_ff     <= discard_in;
            id_left_ff     <= id_left_in;
         end
      end
   end

endmodule

// ----- hdl/wfcs_queue.sv -----
module wfcs_queue
   import wfcs_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head_desc,
   output logic     full,
   output logic     empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   desc_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/wfcs_back.sv -----
module wfcs_back
   import wfcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  desc_type head_desc,
   input  logic     empty,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   function automatic rsp_type bus_op(input logic [1:0] kind, input logic [23:0] addr,
                                      input logic [15:0] data, input logic [1:0] status);
      rsp_type r;
      r.out_kind    = kind;
      r.bus_addr    = addr;
      r.bus_data    = data;
      r.done_status = status;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic rsp_type step_result(input desc_type d, input logic [2:0] step);
      rsp_type r;
      logic [15:0] cnt16;
      cnt16 = {7'd0, d.count};
      r = bus_op(KIND_DONE, ADDR_ZERO, 16'd0, d.status);
      case (d.op)
         OP_ID: begin
            case (step)
               3'd0: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               3'd1: r = bus_op(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               3'd2: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_AUTOSEL, ST_OK);
               3'd3: r = bus_op(KIND_READ, ADDR_ID0, 16'd0, ST_OK);
               3'd4: r = bus_op(KIND_READ, ADDR_ID1, 16'd0, ST_OK);
               3'd5: r = bus_op(KIND_READ, ADDR_ID2, 16'd0, ST_OK);
               default: r = bus_op(KIND_READ, ADDR_ID3, 16'd0, ST_OK);
            endcase
         end
         OP_CHIP, OP_SECTOR: begin
            case (step)
               3'd0: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               3'd1: r = bus_op(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               3'd2: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_ERASE, ST_OK);
               3'd3: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               3'd4: r = bus_op(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               3'd5: begin
                  if (d.op == OP_CHIP) begin
                     r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_CHIP, ST_OK);
                  end else begin
                     r = bus_op(KIND_WRITE, d.addr_a, CMD_SECTOR, ST_OK);
                  end
               end
               default: begin
                  if (d.op == OP_CHIP) begin
                     r = bus_op(KIND_DONE, ADDR_ZERO, 16'd0, ST_OK);
                  end else begin
                     r = bus_op(KIND_READ, d.addr_a, 16'd0, ST_OK);
                  end
               end
            endcase
         end
         OP_PROG: begin
            case (step)
               3'd0: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               3'd1: r = bus_op(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               3'd2: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_PROGRAM, ST_OK);
               3'd3: r = bus_op(KIND_WRITE, d.addr_a, d.data, ST_OK);
               default: r = bus_op(KIND_READ, d.addr_a, 16'd0, ST_OK);
            endcase
         end
         OP_BUF: begin
            case (step)
               3'd0: r = bus_op(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               3'd1: r = bus_op(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               3'd2: r = bus_op(KIND_WRITE, d.addr_b, CMD_WBUF, ST_OK);
               3'd3: r = bus_op(KIND_WRITE, d.addr_b, cnt16, ST_OK);
               3'd4: r = bus_op(KIND_WRITE, d.addr_a, d.data, ST_OK);
               3'd5: r = bus_op(KIND_WRITE, d.addr_b, CMD_WBUF_GO, ST_OK);
               default: r = bus_op(KIND_READ, d.addr_a, 16'd0, ST_OK);
            endcase
         end
         OP_IDWORD: begin
            case (step)
               3'd0: r = bus_op(KIND_ID, ADDR_ZERO, d.data, ST_OK);
               3'd1: r = bus_op(KIND_WRITE, ADDR_ZERO, CMD_RESET, ST_OK);
               default: r = bus_op(KIND_DONE, ADDR_ZERO, 16'd0, ST_OK);
            endcase
         end
         OP_MATCH: begin
            case (step)
               3'd0, 3'd1: r = bus_op(KIND_READ, d.addr_a, 16'd0, ST_OK);
               default: r = bus_op(KIND_DONE, ADDR_ZERO, 16'd0, ST_OK);
            endcase
         end
         OP_POLL: begin
            r = bus_op(KIND_READ, d.addr_a, 16'd0, ST_OK);
         end
         default: begin
            r = bus_op(KIND_DONE, ADDR_ZERO, 16'd0, d.status);
         end
      endcase
      return r;
   endfunction

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] off_ff, off_in;
   logic [2:0] step;
   logic       advance;
   logic       produce;
   logic       at_end;

   assign step    = head_desc.first_step + off_ff;
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign produce = advance && !empty;
   assign at_end  = (step == head_desc.final_step);
   assign pop     = produce && at_end;

   always_comb begin
      rsp_in       = step_result(head_desc, step);
      rsp_in.last  = at_end;
      rsp_valid_in = advance ? !empty : rsp_valid_ff;
      off_in       = off_ff;
      if (produce) begin
         off_in = at_end ? 3'd0 : off_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         off_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         off_ff       <= off_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- verif/word_flash_command_sequencer_tb.sv -----
`timescale 1ns / 1ps

module word_flash_command_sequencer_tb;
   import wfcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 12;
   localparam int DIR_ROWS       = 26;
   localparam int PHASE_ITEMS    = 44;

   typedef struct packed {
      logic        is_csr;
      logic [15:0] csr_val;
      req_type     item;
      logic        typed;
      logic        typed_one;
      rsp_type     typed_rsp;
   } dir_row_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data    = '0;

   // flash sequencer shadow state
   logic [15:0] fl_timeout    = TIMEOUT_RESET;
   logic        fl_polling    = 1'b0;
   logic [23:0] fl_poll_addr  = '0;
   logic        fl_dq7        = 1'b0;
   logic [15:0] fl_ticks      = '0;
   logic [23:0] fl_chunk_base = '0;
   logic [8:0]  fl_chunk_off  = '0;
   logic [1:0]  fl_swallow    = '0;
   logic [2:0]  fl_id_left    = '0;

   rsp_type     op_buf [0:7];
   int          op_cnt = 0;
   rsp_type     expected_bus_ops [$];
   dir_row_type dir_tab [0:DIR_ROWS-1];

   int snd_pct        = 0;
   int rcv_pct        = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_cnt       = 0;
   int mismatch_count = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;

   word_flash_command_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   function automatic req_type mk_req(req_kind_type k, logic [24:0] a, logic [15:0] d,
                                      logic [8:0] len, logic f, logic l, logic [15:0] rv);
      req_type it;
      it.req_type    = k;
      it.byte_addr   = a;
      it.data_word   = d;
      it.chunk_len   = len;
      it.chunk_first = f;
      it.chunk_last  = l;
      it.read_value  = rv;
      return it;
   endfunction

   function automatic rsp_type mk_rsp(logic [1:0] k, logic [23:0] a, logic [15:0] d,
                                      logic [1:0] s, logic l);
      rsp_type r;
      r.out_kind    = k;
      r.bus_addr    = a;
      r.bus_data    = d;
      r.done_status = s;
      r.last        = l;
      return r;
   endfunction

   function automatic dir_row_type pred_row(req_type it);
      dir_row_type r;
      r = '0;
      r.item = it;
      return r;
   endfunction

   function automatic dir_row_type none_row(req_type it);
      dir_row_type r;
      r = '0;
      r.item  = it;
      r.typed = 1'b1;
      return r;
   endfunction

   function automatic dir_row_type one_row(req_type it, rsp_type want);
      dir_row_type r;
      r = '0;
      r.item      = it;
      r.typed     = 1'b1;
      r.typed_one = 1'b1;
      r.typed_rsp = want;
      return r;
   endfunction

   function automatic void emit(logic [1:0] k, logic [23:0] a, logic [15:0] d, logic [1:0] s);
      op_buf[op_cnt] = mk_rsp(k, a, d, s, 1'b0);
      op_cnt++;
   endfunction

   function automatic void add_swallow(int k);
      int s;
      s = int'(fl_swallow) + k;
      fl_swallow = (s > 3) ? 2'd3 : s[1:0];
   endfunction

   function automatic void start_poll(logic [23:0] a, logic b);
      fl_polling   = 1'b1;
      fl_poll_addr = a;
      fl_dq7       = b;
      fl_ticks     = '0;
   endfunction

   function automatic void sequence_flash_item(req_type it);
      logic [23:0] wa;
      logic [23:0] sec;
      logic [23:0] pa;
      logic [8:0]  len;
      logic        idle;
      rsp_type     r;
      wa   = it.byte_addr[24:1];
      idle = !fl_polling && fl_id_left == 3'd0 && fl_chunk_off == 9'd0;
      op_cnt = 0;
      case (req_kind_type'(it.req_type))
         REQ_ID: begin
            if (idle) begin
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_AUTOSEL, ST_OK);
               emit(KIND_READ, ADDR_ID0, 16'h0, ST_OK);
               emit(KIND_READ, ADDR_ID1, 16'h0, ST_OK);
               emit(KIND_READ, ADDR_ID2, 16'h0, ST_OK);
               emit(KIND_READ, ADDR_ID3, 16'h0, ST_OK);
               fl_id_left = 3'd4;
            end
         end
         REQ_CHIP_ERASE, REQ_SECTOR_ERASE: begin
            if (idle) begin
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_ERASE, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               if (req_kind_type'(it.req_type) == REQ_CHIP_ERASE) begin
                  emit(KIND_WRITE, ADDR_UNLOCK1, CMD_CHIP, ST_OK);
                  emit(KIND_DONE, ADDR_ZERO, 16'h0, ST_OK);
               end else begin
                  sec = wa & SECTOR_MASK;
                  emit(KIND_WRITE, sec, CMD_SECTOR, ST_OK);
                  emit(KIND_READ, sec, 16'h0, ST_OK);
                  start_poll(sec, 1'b1);
               end
            end
         end
         REQ_PROGRAM: begin
            if (idle) begin
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
               emit(KIND_WRITE, ADDR_UNLOCK1, CMD_PROGRAM, ST_OK);
               emit(KIND_WRITE, wa, it.data_word, ST_OK);
               emit(KIND_READ, wa, 16'h0, ST_OK);
               start_poll(wa, it.data_word[DQ7_BIT]);
            end
         end
         REQ_BUFFER: begin
            if (!fl_polling && fl_id_left == 3'd0 &&
                (it.chunk_first || fl_chunk_off != 9'd0)) begin
               if (it.chunk_first) begin
                  len = it.chunk_len;
                  if (len == 9'd0) len = 9'd1;
                  if (len > 9'(MAX_CHUNK_WORDS_DEF)) len = 9'(MAX_CHUNK_WORDS_DEF);
                  fl_chunk_base = wa;
                  emit(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1, ST_OK);
                  emit(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2, ST_OK);
                  emit(KIND_WRITE, wa, CMD_WBUF, ST_OK);
                  emit(KIND_WRITE, wa, {7'd0, len - 9'd1}, ST_OK);
                  pa = wa;
                  fl_chunk_off = 9'd1;
               end else begin
                  pa = fl_chunk_base + {15'd0, fl_chunk_off};
                  fl_chunk_off = fl_chunk_off + 9'd1;
               end
               emit(KIND_WRITE, pa, it.data_word, ST_OK);
               if (it.chunk_last) begin
                  emit(KIND_WRITE, fl_chunk_base, CMD_WBUF_GO, ST_OK);
                  emit(KIND_READ, pa, 16'h0, ST_OK);
                  start_poll(pa, it.data_word[DQ7_BIT]);
                  fl_chunk_off = '0;
               end
            end
         end
         REQ_READ_RETURN: begin
            if (fl_swallow != 2'd0) begin
               fl_swallow = fl_swallow - 2'd1;
            end else if (fl_id_left != 3'd0) begin
               emit(KIND_ID, ADDR_ZERO, it.read_value, ST_OK);
               fl_id_left = fl_id_left - 3'd1;
               if (fl_id_left == 3'd0) begin
                  emit(KIND_WRITE, ADDR_ZERO, CMD_RESET, ST_OK);
                  emit(KIND_DONE, ADDR_ZERO, 16'h0, ST_OK);
               end
            end else if (fl_polling) begin
               if (it.read_value[DQ7_BIT] == fl_dq7) begin
                  emit(KIND_READ, fl_poll_addr, 16'h0, ST_OK);
                  emit(KIND_READ, fl_poll_addr, 16'h0, ST_OK);
                  emit(KIND_DONE, ADDR_ZERO, 16'h0, ST_OK);
                  add_swallow(2);
                  fl_polling = 1'b0;
               end else begin
                  emit(KIND_READ, fl_poll_addr, 16'h0, ST_OK);
               end
            end
         end
         REQ_TICK: begin
            if (fl_polling) begin
               if (fl_ticks >= fl_timeout) begin
                  emit(KIND_DONE, ADDR_ZERO, 16'h0, ST_TIMEOUT);
                  fl_polling = 1'b0;
                  add_swallow(1);
               end else begin
                  fl_ticks = fl_ticks + 16'd1;
               end
            end
         end
         default: begin
            if (!idle) begin
               emit(KIND_DONE, ADDR_ZERO, 16'h0, ST_ABORT);
               if (fl_polling) add_swallow(1);
               add_swallow(int'(fl_id_left));
               fl_polling   = 1'b0;
               fl_id_left   = '0;
               fl_chunk_off = '0;
            end
         end
      endcase
      if (op_cnt > 0) begin
         r = op_buf[op_cnt-1];
         r.last = 1'b1;
         op_buf[op_cnt-1] = r;
      end
   endfunction

   function automatic req_type pick_random_item();
      req_type     it;
      logic [31:0] w;
      int          roll;
      w = $urandom();
      it.byte_addr   = w[24:0];
      it.req_type    = w[27:25];
      it.chunk_first = w[28];
      it.chunk_last  = w[29];
      w = $urandom();
      it.data_word  = w[15:0];
      it.read_value = w[31:16];
      w = $urandom();
      it.chunk_len = w[8:0];
      roll = $urandom_range(0, 99);
      if (roll < 12) return it;
      roll = $urandom_range(0, 99);
      if (fl_id_left != 3'd0 || fl_swallow != 2'd0) begin
         it.req_type = (roll < 94) ? REQ_READ_RETURN : REQ_ABORT;
      end else if (fl_polling) begin
         if (roll < 55) it.req_type = REQ_READ_RETURN;
         else if (roll < 88) it.req_type = REQ_TICK;
         else if (roll < 94) it.req_type = REQ_ABORT;
         else begin
            w = $urandom_range(0, 4);
            it.req_type = w[2:0];
         end
      end else if (fl_chunk_off != 9'd0) begin
         it.req_type    = (roll < 95) ? REQ_BUFFER : REQ_ABORT;
         it.chunk_first = ($urandom_range(0, 99) < 8);
         it.chunk_last  = ($urandom_range(0, 99) < 30);
      end else begin
         if (roll < 15) it.req_type = REQ_ID;
         else if (roll < 25) it.req_type = REQ_CHIP_ERASE;
         else if (roll < 45) it.req_type = REQ_SECTOR_ERASE;
         else if (roll < 70) it.req_type = REQ_PROGRAM;
         else if (roll < 93) it.req_type = REQ_BUFFER;
         else it.req_type = REQ_TICK;
         it.chunk_first = 1'b1;
         it.chunk_last  = ($urandom_range(0, 99) < 25);
         if ($urandom_range(0, 99) < 90) begin
            w = $urandom_range(1, 8);
            it.chunk_len = w[8:0];
         end
      end
      return it;
   endfunction

   task automatic push_ops();
      for (int i = 0; i < op_cnt; i++) expected_bus_ops.push_back(op_buf[i]);
   endtask

   task automatic send_item(input req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sequence_flash_item(it);
      items_sent++;
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bus_ops.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fl_timeout = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall, plus one long hold on request
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_cnt  = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_bus_ops.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 40)
               $display("%0t unexpected transaction: expected none, actual %0d %h %h %0d %0b",
                        $time, rsp_payload.out_kind, rsp_payload.bus_addr,
                        rsp_payload.bus_data, rsp_payload.done_status, rsp_payload.last);
         end else begin
            want = expected_bus_ops.pop_front();
            if (rsp_payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= 40)
                  $display("%0t mismatch: exp %0d %h %h %0d %0b, act %0d %h %h %0d %0b",
                           $time, want.out_kind, want.bus_addr, want.bus_data,
                           want.done_status, want.last, rsp_payload.out_kind,
                           rsp_payload.bus_addr, rsp_payload.bus_data,
                           rsp_payload.done_status, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int         i;
      int         ph;
      int         active;
      logic [15:0] ph_timeout;
      dir_tab[0]  = pred_row(mk_req(REQ_ID, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[1]  = one_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'hFFFF),
                            mk_rsp(KIND_ID, ADDR_ZERO, 16'hFFFF, ST_OK, 1'b1));
      dir_tab[2]  = one_row(mk_req(REQ_READ_RETURN, 25'h1FFFFFF, 16'hFFFF, 9'h1FF, 1'b1, 1'b1,
                                   16'h0000),
                            mk_rsp(KIND_ID, ADDR_ZERO, 16'h0000, ST_OK, 1'b1));
      dir_tab[3]  = one_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h1234),
                            mk_rsp(KIND_ID, ADDR_ZERO, 16'h1234, ST_OK, 1'b1));
      dir_tab[4]  = pred_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h5AA5));
      dir_tab[5]  = pred_row(mk_req(REQ_CHIP_ERASE, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[6]  = pred_row(mk_req(REQ_SECTOR_ERASE, 25'h1FFFFFF, 16'h0, 9'd1, 1'b0, 1'b0,
                                    16'h0));
      dir_tab[7]  = none_row(mk_req(REQ_PROGRAM, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[8]  = none_row(mk_req(REQ_TICK, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[9]  = pred_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0000));
      dir_tab[10] = pred_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0080));
      dir_tab[11] = none_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0080));
      dir_tab[12] = none_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'hFFFF));
      dir_tab[13] = pred_row(mk_req(REQ_PROGRAM, 25'h0, 16'hFFFF, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[14] = one_row(mk_req(REQ_ABORT, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0),
                            mk_rsp(KIND_DONE, ADDR_ZERO, 16'h0, ST_ABORT, 1'b1));
      dir_tab[15] = none_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'hFFFF));
      dir_tab[16] = none_row(mk_req(REQ_ABORT, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[17] = none_row(mk_req(REQ_BUFFER, 25'h100, 16'h1111, 9'd4, 1'b0, 1'b1, 16'h0));
      dir_tab[18] = pred_row(mk_req(REQ_BUFFER, 25'h1FFFFFF, 16'h0000, 9'd0, 1'b1, 1'b1, 16'h0));
      dir_tab[19] = one_row(mk_req(REQ_ABORT, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0),
                            mk_rsp(KIND_DONE, ADDR_ZERO, 16'h0, ST_ABORT, 1'b1));
      dir_tab[20] = none_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0));
      dir_tab[21] = '0;
      dir_tab[21].is_csr  = 1'b1;
      dir_tab[21].csr_val = 16'h0000;
      dir_tab[22] = pred_row(mk_req(REQ_BUFFER, 25'h1FFFFFE, 16'h0080, 9'h1FF, 1'b1, 1'b0,
                                    16'h0));
      dir_tab[23] = pred_row(mk_req(REQ_BUFFER, 25'h0, 16'hFFFF, 9'd1, 1'b0, 1'b1, 16'h0));
      dir_tab[24] = one_row(mk_req(REQ_TICK, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0),
                            mk_rsp(KIND_DONE, ADDR_ZERO, 16'h0, ST_TIMEOUT, 1'b1));
      dir_tab[25] = none_row(mk_req(REQ_READ_RETURN, 25'h0, 16'h0, 9'd1, 1'b0, 1'b0, 16'h0080));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].is_csr) begin
            drain_and_settle();
            csr_write(dir_tab[i].csr_val);
         end else begin
            send_item(dir_tab[i].item);
            if (!dir_tab[i].typed) push_ops();
            else if (dir_tab[i].typed_one) expected_bus_ops.push_back(dir_tab[i].typed_rsp);
         end
      end

      for (ph = 0; ph < 4; ph++) begin
         drain_and_settle();
         case (ph)
            0: begin ph_timeout = 16'hFFFF; snd_pct = 0;  rcv_pct = 0;  end
            1: begin ph_timeout = 16'd3;    snd_pct = 73; rcv_pct = 0;  end
            2: begin ph_timeout = 16'd1;    snd_pct = 0;  rcv_pct = 73; end
            default: begin ph_timeout = 16'd10000; snd_pct = 10; rcv_pct = 10; end
         endcase
         csr_write(ph_timeout);
         // hold the result side while requests keep coming
         if (ph == 0) hold_req++;
         active = 0;
         while (active < PHASE_ITEMS) begin
            send_item(pick_random_item());
            push_ops();
            active++;
         end
      end

      drain_and_settle();
      $display("Covered %0d requests (directed table, then four random phases) and %0d results",
               items_sent, results_seen);
      $display("Phases: full rate with a %0d-cycle hold, idle sender, stalling receiver, both",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- word_flash_command_sequencer.f -----
hdl/wfcs_pkg.sv
hdl/wfcs_front.sv
hdl/wfcs_queue.sv
hdl/wfcs_back.sv
hdl/word_flash_command_sequencer.sv
verif/word_flash_command_sequencer_tb.sv
